/* rtl/pse_pkg.sv */
// pse_pkg: shared types, codes and defaults of the postfix stack evaluator
// used by every module under rtl; depends on nothing

package pse_pkg;

    localparam int PSE_STACK_DEPTH   = 16;
    localparam int PSE_FRACTION_BITS = 16;

    localparam int DIV_STEPS  = 32;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // token kinds
    localparam logic [2:0] OP_PUSH = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNDERFLOW = 3'd1;
    localparam logic [2:0] ST_DIVZERO   = 3'd2;
    localparam logic [2:0] ST_UNKNOWN   = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;
    localparam logic [2:0] ST_BADFINAL  = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_MUL,
        S_DIV,
        S_RESULT
    } t_state;

    typedef enum logic [1:0] {
        RES_ADDSUB,
        RES_MUL,
        RES_DIV
    } t_res_sel;

    typedef struct packed {
        logic       capture;
        logic       push;
        logic       set_err;
        logic [2:0] err_code;
        logic       read_left;
        logic       write_res;
        t_res_sel   res_sel;
        logic       mul_load;
        logic       div_start;
        logic       load_out;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       has_err;
        logic       full;
        logic       few;
        logic       b_zero;
        logic       div_done;
        logic       out_free;
    } t_sts;

endpackage

/* rtl/postfix_stack_evaluator_unit.sv */
// postfix_stack_evaluator_unit: top level of the postfix stack evaluator
// depends on pse_pkg, pse_ctrl, pse_datapath (and pse_div below it)
//
// Usage: one token per request on the slave stream. i_s_tuser carries the token
// kind (push, add, subtract, multiply, divide, anything else unknown), i_s_tdata
// the signed fixed point operand and i_s_tlast marks the final token of an
// expression. Every token gives exactly one result request on the master stream:
// o_m_tuser is the status, o_m_tdata the top of stack (or the final value) and
// o_m_tlast closes the expression. Errors stick until the final token.
// Push, a stack error or a token after an error go from decode to the result;
// operators first read the left operand, multiply then registers the product
// and divide waits for the divider, one quotient bit a cycle over 32 bits. The
// next token can be taken in the cycle after the result is registered.
// The stack is a memory read through one registered port, one operand per token.
// Reset empties the stack and clears the sticky error; stack contents are not
// cleared. When the receiver stalls the result stays in the output register and
// the next token is still taken and worked; its result waits until that register
// frees, and no further token is accepted meanwhile.

module postfix_stack_evaluator_unit
    import pse_pkg::*;
#(
    parameter int STACK_DEPTH   = PSE_STACK_DEPTH,
    parameter int FRACTION_BITS = PSE_FRACTION_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // operand_value
    input  logic [2:0]  i_s_tuser,   // operation
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // value
    output logic [2:0]  o_m_tuser,   // status
    output logic        o_m_tlast
);

    t_cmd w_cmd;
    t_sts w_sts;

    pse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pse_datapath #(
        .STACK_DEPTH   (STACK_DEPTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

/* rtl/pse_div.sv */
// pse_div: iterative radix-2 signed fixed point divider, one quotient bit a cycle
// depends on pse_pkg

module pse_div
    import pse_pkg::*;
#(
    parameter int FRACTION_BITS = PSE_FRACTION_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [31:0]          r_rem;
    logic [31:0]          r_quo;
    logic [31:0]          r_div;
    logic                 r_neg;
    logic                 r_ovf;

    logic [31:0] n_mag_a;
    logic [31:0] n_mag_b;
    logic [63:0] n_wide;
    logic [32:0] n_trial;
    logic        n_ge;
    logic [32:0] n_diff;

    assign n_mag_a = i_dividend[31] ? (32'd0 - i_dividend) : i_dividend;
    assign n_mag_b = i_divisor[31] ? (32'd0 - i_divisor) : i_divisor;
    assign n_wide  = {32'd0, n_mag_a} << FRACTION_BITS;
    assign n_trial = {r_rem, r_quo[31]};
    assign n_ge    = n_trial >= {1'b0, r_div};
    assign n_diff  = n_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= n_wide[63:32];
            r_quo <= n_wide[31:0];
            r_div <= n_mag_b;
            r_neg <= i_dividend[31] ^ i_divisor[31];
            r_ovf <= n_wide[63:32] >= n_mag_b;
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[31:0] : n_trial[31:0];
            r_quo <= {r_quo[30:0], n_ge};
        end
    end

    // saturate the magnitude quotient back to signed
    always_comb begin
        if (r_ovf) begin
            o_quotient = r_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if (r_neg) begin
            o_quotient = (r_quo > 32'h8000_0000) ? 32'h8000_0000 : (32'd0 - r_quo);
        end else begin
            o_quotient = (r_quo > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : r_quo;
        end
    end

    assign o_done = r_done;

    property p_start_idle;
        @(posedge i_clk) disable iff (!i_rst_n) i_start |-> !r_busy;
    endproperty
    a_start_idle: assert property (p_start_idle) else $error("divider restarted while busy");

    property p_done_after_busy;
        @(posedge i_clk) disable iff (!i_rst_n) r_done |-> $past(r_busy) && !r_busy;
    endproperty
    a_done_after_busy: assert property (p_done_after_busy) else $error("done without iteration");

    property p_done_single;
        @(posedge i_clk) disable iff (!i_rst_n) r_done |=> !r_done;
    endproperty
    a_done_single: assert property (p_done_single) else $error("done held longer than a cycle");

endmodule

/* rtl/pse_datapath.sv */
// pse_datapath: stack memory, top-of-stack register, arithmetic and output register
// depends on pse_pkg and pse_div

module pse_datapath
    import pse_pkg::*;
#(
    parameter int STACK_DEPTH   = PSE_STACK_DEPTH,
    parameter int FRACTION_BITS = PSE_FRACTION_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [31:0] i_s_tdata,
    input  logic [2:0]  i_s_tuser,
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,
    output logic [2:0]  o_m_tuser,
    output logic        o_m_tlast
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int IW = $clog2(STACK_DEPTH);
    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    logic [31:0]        r_mem [STACK_DEPTH];
    logic [2:0]         r_op;
    logic [31:0]        r_operand;
    logic               r_last;
    logic [CW-1:0]      r_count;
    logic [2:0]         r_err;
    logic [31:0]        r_tos;
    logic [31:0]        r_left;
    logic signed [63:0] r_prod;
    logic               r_out_valid;
    logic [31:0]        r_out_value;
    logic [2:0]         r_out_status;
    logic               r_out_last;

    logic [CW-1:0]      n_cnt_m2;
    logic [IW-1:0]      n_pair_idx;
    logic [IW-1:0]      n_push_idx;
    logic signed [32:0] n_sum;
    logic [31:0]        n_addsub;
    logic signed [63:0] n_shr;
    logic [31:0]        n_mul;
    logic [31:0]        n_div;
    logic               n_div_done;
    logic [31:0]        n_res;
    logic [2:0]         n_out_status;
    logic [31:0]        n_out_value;

    assign n_cnt_m2   = r_count - CW'(2);
    assign n_pair_idx = n_cnt_m2[IW-1:0];
    assign n_push_idx = r_count[IW-1:0];

    assign n_sum = (r_op == OP_SUB)
                 ? ($signed({r_left[31], r_left}) - $signed({r_tos[31], r_tos}))
                 : ($signed({r_left[31], r_left}) + $signed({r_tos[31], r_tos}));
    assign n_addsub = (n_sum[32] != n_sum[31])
                    ? (n_sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : n_sum[31:0];

    // arithmetic shift rounds toward minus infinity
    assign n_shr = r_prod >>> FRACTION_BITS;
    assign n_mul = (n_shr > SAT_MAX) ? 32'h7FFF_FFFF
                 : (n_shr < SAT_MIN) ? 32'h8000_0000 : n_shr[31:0];

    pse_div #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_left),
        .i_divisor  (r_tos),
        .o_done     (n_div_done),
        .o_quotient (n_div)
    );

    always_comb begin
        unique case (i_cmd.res_sel)
            RES_ADDSUB: n_res = n_addsub;
            RES_MUL:    n_res = n_mul;
            RES_DIV:    n_res = n_div;
            default:    n_res = n_addsub;
        endcase
    end

    always_comb begin
        if (r_last) begin
            if (r_err != ST_OK) begin
                n_out_status = r_err;
                n_out_value  = '0;
            end else if (r_count != CW'(1)) begin
                n_out_status = ST_BADFINAL;
                n_out_value  = '0;
            end else begin
                n_out_status = ST_OK;
                n_out_value  = r_tos;
            end
        end else begin
            n_out_status = r_err;
            n_out_value  = (r_count != '0) ? r_tos : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[n_push_idx] <= r_operand;
        end else if (i_cmd.write_res) begin
            r_mem[n_pair_idx] <= n_res;
        end
        if (i_cmd.read_left) begin
            r_left <= r_mem[n_pair_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op      <= i_s_tuser;
            r_operand <= i_s_tdata;
            r_last    <= i_s_tlast;
        end
        if (i_cmd.push) begin
            r_tos <= r_operand;
        end else if (i_cmd.write_res) begin
            r_tos <= n_res;
        end
        if (i_cmd.mul_load) begin
            r_prod <= $signed(r_left) * $signed(r_tos);
        end
        if (i_cmd.load_out) begin
            r_out_value  <= n_out_value;
            r_out_status <= n_out_status;
            r_out_last   <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.push) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.write_res) begin
                r_count <= r_count - CW'(1);
            end else if (i_cmd.load_out && r_last) begin
                r_count <= '0;
            end
            if (i_cmd.set_err) begin
                r_err <= i_cmd.err_code;
            end else if (i_cmd.load_out && r_last) begin
                r_err <= ST_OK;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.op       = r_op;
    assign o_sts.has_err  = r_err != ST_OK;
    assign o_sts.full     = r_count >= CW'(STACK_DEPTH);
    assign o_sts.few      = r_count < CW'(2);
    assign o_sts.b_zero   = r_tos == '0;
    assign o_sts.div_done = n_div_done;
    assign o_sts.out_free = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_value;
    assign o_m_tuser  = r_out_status;
    assign o_m_tlast  = r_out_last;

    property p_push_room;
        @(posedge i_clk) disable iff (!i_rst_n) i_cmd.push |-> r_count < CW'(STACK_DEPTH);
    endproperty
    a_push_room: assert property (p_push_room) else $error("push onto full stack");

    property p_pair_present;
        @(posedge i_clk) disable iff (!i_rst_n)
            (i_cmd.write_res || i_cmd.read_left) |-> r_count >= CW'(2);
    endproperty
    a_pair_present: assert property (p_pair_present) else $error("operator with short stack");

    property p_err_sticky;
        @(posedge i_clk) disable iff (!i_rst_n) i_cmd.set_err |-> r_err == ST_OK;
    endproperty
    a_err_sticky: assert property (p_err_sticky) else $error("error overwritten");

    property p_final_clears;
        @(posedge i_clk) disable iff (!i_rst_n)
            (i_cmd.load_out && r_last) |=> (r_count == '0) && (r_err == ST_OK);
    endproperty
    a_final_clears: assert property (p_final_clears) else $error("stack not cleared at end");

endmodule

/* rtl/pse_ctrl.sv */
// pse_ctrl: token sequencer, drives datapath commands from its status
// depends on pse_pkg

module pse_ctrl
    import pse_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) n_state = S_DECODE;
            end
            S_DECODE: begin
                priority if (i_sts.has_err || i_sts.op == OP_PUSH || i_sts.few
                             || i_sts.op > OP_DIV) begin
                    n_state = S_RESULT;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                priority if (i_sts.op == OP_MUL) begin
                    n_state = S_MUL;
                end else if (i_sts.op == OP_DIV && !i_sts.b_zero) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_MUL: n_state = S_RESULT;
            S_DIV: begin
                if (i_sts.div_done) n_state = S_RESULT;
            end
            S_RESULT: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready    = 1'b1;
                o_cmd.capture = i_s_tvalid;
            end
            S_DECODE: begin
                if (!i_sts.has_err) begin
                    priority if (i_sts.op == OP_PUSH) begin
                        if (i_sts.full) begin
                            o_cmd.set_err  = 1'b1;
                            o_cmd.err_code = ST_OVERFLOW;
                        end else begin
                            o_cmd.push = 1'b1;
                        end
                    end else if (i_sts.few) begin
                        o_cmd.set_err  = 1'b1;
                        o_cmd.err_code = ST_UNDERFLOW;
                    end else if (i_sts.op > OP_DIV) begin
                        o_cmd.set_err  = 1'b1;
                        o_cmd.err_code = ST_UNKNOWN;
                    end else begin
                        o_cmd.read_left = 1'b1;
                    end
                end
            end
            S_READ: begin
                priority if (i_sts.op == OP_MUL) begin
                    o_cmd.mul_load = 1'b1;
                end else if (i_sts.op == OP_DIV) begin
                    if (i_sts.b_zero) begin
                        o_cmd.set_err  = 1'b1;
                        o_cmd.err_code = ST_DIVZERO;
                    end else begin
                        o_cmd.div_start = 1'b1;
                    end
                end else begin
                    o_cmd.write_res = 1'b1;
                    o_cmd.res_sel   = RES_ADDSUB;
                end
            end
            S_MUL: begin
                o_cmd.write_res = 1'b1;
                o_cmd.res_sel   = RES_MUL;
            end
            S_DIV: begin
                o_cmd.write_res = i_sts.div_done;
                o_cmd.res_sel   = RES_DIV;
            end
            S_RESULT: begin
                o_cmd.load_out = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    property p_div_wait;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == S_DIV && !i_sts.div_done) |=> r_state == S_DIV;
    endproperty
    a_div_wait: assert property (p_div_wait) else $error("left divide before quotient");

    property p_result_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == S_RESULT && !i_sts.out_free) |=> r_state == S_RESULT;
    endproperty
    a_result_hold: assert property (p_result_hold) else $error("result dropped");

    property p_one_request;
        @(posedge i_clk) disable iff (!i_rst_n)
            o_cmd.capture |=> !o_s_tready;
    endproperty
    a_one_request: assert property (p_one_request) else $error("second request taken early");

endmodule

/* verif/tb.sv */
// tb: self-checking bench for postfix_stack_evaluator_unit; streams postfix tokens,
// predicts every status/value result with an in-bench stack model and compares them
// depends on pse_pkg and the rtl under rtl/

module tb import pse_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = PSE_STACK_DEPTH;
    localparam int FRAC  = PSE_FRACTION_BITS;

    localparam logic [2:0] OP_UNKNOWN    = 3'd5;
    localparam logic [2:0] OP_UNKNOWN_HI = 3'd7;

    localparam logic [31:0] Q_MAX        = 32'h7fff_ffff;
    localparam logic [31:0] Q_MIN        = 32'h8000_0000;
    localparam logic [31:0] Q_ONE        = 32'h0001_0000;
    localparam logic [31:0] Q_MINUS_ONE  = 32'hffff_0000;
    localparam logic [31:0] Q_MINUS_HALF = 32'hffff_8000;
    localparam longint      SAT_HI       = 64'sd2147483647;
    localparam longint      SAT_LO       = -64'sd2147483647 - 64'sd1;

    localparam int N_RANDOM     = 500;
    localparam int QUIET_TAIL   = 60;
    localparam int DRAIN_CYCLES = 80;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] val;
        logic        last;
        logic        hold;
    } t_token;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value;
        logic        done;
    } t_calc_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;   // operand_value
    logic [2:0]  i_s_tuser;   // operation
    logic        i_s_tlast;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;   // value
    logic [2:0]  o_m_tuser;   // status
    logic        o_m_tlast;

    t_token       pending_tokens[$];
    t_calc_result expected_results[$];
    t_token       cur_token;

    logic [31:0] calc_stack [DEPTH];
    int unsigned calc_depth;
    logic [2:0]  calc_err;

    bit          hold_next;
    bit          token_taken;
    logic        next_valid;
    int unsigned idle_in;
    int unsigned stall_out;
    int unsigned mismatches;
    int unsigned tokens_taken;
    int unsigned exprs_closed;
    int unsigned results_seen;
    int unsigned status_seen [8];
    int unsigned n_directed;

    postfix_stack_evaluator_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    function automatic logic [31:0] saturate_q(longint v);
        if (v > SAT_HI) return Q_MAX;
        if (v < SAT_LO) return Q_MIN;
        return v[31:0];
    endfunction

    function automatic void apply_token(logic [2:0] op, logic [31:0] val);
        longint a;
        longint b;
        longint r;
        if (op == OP_PUSH) begin
            if (calc_depth >= DEPTH) begin
                calc_err = ST_OVERFLOW;
            end else begin
                calc_stack[calc_depth] = val;
                calc_depth++;
            end
            return;
        end
        if (calc_depth < 2) begin
            calc_err = ST_UNDERFLOW;
            return;
        end
        b = longint'(signed'(calc_stack[calc_depth - 1]));
        a = longint'(signed'(calc_stack[calc_depth - 2]));
        case (op)
            OP_ADD: r = a + b;
            OP_SUB: r = a - b;
            OP_MUL: r = (a * b) >>> FRAC;
            OP_DIV: begin
                if (b == 0) begin
                    calc_err = ST_DIVZERO;
                    return;
                end
                r = (a <<< FRAC) / b;
            end
            default: begin
                calc_err = ST_UNKNOWN;
                return;
            end
        endcase
        calc_depth--;
        calc_stack[calc_depth - 1] = saturate_q(r);
    endfunction

    function automatic t_calc_result predict_result(t_token t);
        t_calc_result res;
        if (calc_err == ST_OK) apply_token(t.op, t.val);
        res.done = t.last;
        if (t.last) begin
            if (calc_err != ST_OK) begin
                res.status = calc_err;
                res.value  = '0;
            end else if (calc_depth != 1) begin
                res.status = ST_BADFINAL;
                res.value  = '0;
            end else begin
                res.status = ST_OK;
                res.value  = calc_stack[0];
            end
            calc_depth = 0;
            calc_err   = ST_OK;
        end else begin
            res.status = calc_err;
            res.value  = (calc_depth == 0) ? '0 : calc_stack[calc_depth - 1];
        end
        return res;
    endfunction

    function automatic logic [31:0] pick_q();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return Q_MAX;
            2: return Q_MIN;
            3: return (32'($urandom_range(0, 40)) - 32'd20) << FRAC;
            4: return {{16{1'($urandom)}}, 16'($urandom)};
            5: return $urandom_range(0, 1) ? Q_ONE : Q_MINUS_ONE;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_operator();
        if ($urandom_range(0, 19) == 0) return 3'($urandom_range(OP_UNKNOWN, OP_UNKNOWN_HI));
        return 3'($urandom_range(OP_ADD, OP_DIV));
    endfunction

    task automatic add_token(logic [2:0] op, logic [31:0] val, logic last);
        t_token t;
        t.op   = op;
        t.val  = val;
        t.last = last;
        t.hold = hold_next;
        hold_next = 0;
        pending_tokens.push_back(t);
    endtask

    // well-formed expression with random operands and operators
    task automatic add_expression();
        int n_left;
        int live;
        logic [2:0] op;
        n_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, DEPTH) : $urandom_range(1, 5);
        live   = 0;
        while (n_left > 0 || live > 1) begin
            if (live >= 2 && (n_left == 0 || $urandom_range(0, 1) == 1)) begin
                op = pick_operator();
                live--;
                add_token(op, $urandom, n_left == 0 && live == 1);
            end else begin
                n_left--;
                live++;
                add_token(OP_PUSH, pick_q(), n_left == 0 && live == 1);
            end
        end
    endtask

    task automatic add_overflow_run();
        for (int k = 0; k <= DEPTH; k++) add_token(OP_PUSH, pick_q(), k == DEPTH);
    endtask

    task automatic add_noise();
        add_token(3'($urandom_range(OP_PUSH, OP_UNKNOWN_HI)), pick_q(),
                  $urandom_range(0, 4) == 0);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // sender side
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            next_valid = i_s_tvalid;
            if (token_taken) begin
                token_taken = 0;
                next_valid  = 1'b0;
                if (pending_tokens.size() >= QUIET_TAIL && $urandom_range(0, 3) == 0)
                    idle_in = $urandom_range(1, 4);
            end
            if (!next_valid) begin
                if (idle_in > 0) begin
                    idle_in--;
                end else if (pending_tokens.size() > 0 &&
                             (!pending_tokens[0].hold || expected_results.size() == 0)) begin
                    cur_token  = pending_tokens.pop_front();
                    next_valid = 1'b1;
                    i_s_tuser <= cur_token.op;
                    i_s_tdata <= cur_token.val;
                    i_s_tlast <= cur_token.last;
                end
            end
            i_s_tvalid <= next_valid;
        end
    end

    // receiver side
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (stall_out > 0) begin
                stall_out--;
                i_m_tready <= 1'b0;
            end else if (pending_tokens.size() >= QUIET_TAIL && $urandom_range(0, 4) == 0) begin
                stall_out = $urandom_range(1, 4) - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_calc_result want;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                results_seen++;
                status_seen[o_m_tuser]++;
                if (expected_results.size() == 0) begin
                    if (mismatches < MAX_REPORTS)
                        $display("%0t: result request with nothing pending: %s %0d %h %b",
                                 $realtime, "status/value/last", o_m_tuser, o_m_tdata,
                                 o_m_tlast);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_m_tuser !== want.status || o_m_tdata !== want.value ||
                        o_m_tlast !== want.done) begin
                        if (mismatches < MAX_REPORTS)
                            $display({"%0t: mismatch: expected status %0d value %h last %b,",
                                      " got status %0d value %h last %b"},
                                     $realtime, want.status, want.value, want.done,
                                     o_m_tuser, o_m_tdata, o_m_tlast);
                        mismatches++;
                    end
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                expected_results.push_back(predict_result(cur_token));
                token_taken = 1;
                tokens_taken++;
                if (cur_token.last) exprs_closed++;
            end
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = OP_PUSH;
        i_s_tlast  = 1'b0;
        i_m_tready = 1'b0;
        calc_depth = 0;
        calc_err   = ST_OK;
        foreach (calc_stack[k]) calc_stack[k] = '0;

        // saturating add and subtract, then divide by zero on the last token
        add_token(OP_PUSH, Q_MAX, 0);
        add_token(OP_PUSH, 32'd1, 0);
        add_token(OP_ADD, '0, 0);
        add_token(OP_PUSH, Q_MIN, 0);
        add_token(OP_SUB, '0, 0);
        add_token(OP_PUSH, '0, 0);
        add_token(OP_DIV, '0, 1);
        // operator on an empty stack, underflow wins over unknown
        add_token(OP_UNKNOWN_HI, Q_MAX, 1);
        // min over minus one, floor of a negative product, unknown then sticky
        add_token(OP_PUSH, Q_MIN, 0);
        add_token(OP_PUSH, Q_MINUS_ONE, 0);
        add_token(OP_DIV, '0, 0);
        add_token(OP_PUSH, Q_MINUS_HALF, 0);
        add_token(OP_MUL, '0, 0);
        add_token(OP_PUSH, '0, 0);
        add_token(OP_UNKNOWN, '0, 0);
        add_token(OP_PUSH, Q_ONE, 0);
        add_token(OP_SUB, '0, 1);
        // two values left at the end
        add_token(OP_PUSH, 32'h0003_0000, 0);
        add_token(OP_PUSH, 32'h0004_0000, 1);
        // push past a full stack
        add_overflow_run();
        n_directed = pending_tokens.size();

        hold_next = 1;
        while (pending_tokens.size() < n_directed + N_RANDOM) begin
            case ($urandom_range(0, 9))
                0, 1: add_noise();
                2: begin
                    if ($urandom_range(0, 3) == 0) add_overflow_run();
                    else add_noise();
                end
                default: begin
                    if ($urandom_range(0, 29) == 0) hold_next = 1;
                    add_expression();
                end
            endcase
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        @(posedge i_clk);
        while (pending_tokens.size() > 0 || i_s_tvalid) @(posedge i_clk);
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run: %0d tokens in %0d expressions (%0d directed), %0d results checked",
                 tokens_taken, exprs_closed, n_directed, results_seen);
        $display("statuses: ok %0d underflow %0d div0 %0d unknown %0d overflow %0d bad final %0d",
                 status_seen[ST_OK], status_seen[ST_UNDERFLOW], status_seen[ST_DIVZERO],
                 status_seen[ST_UNKNOWN], status_seen[ST_OVERFLOW], status_seen[ST_BADFINAL]);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
